// ===== rtl/afct_pkg.sv =====
// Shared widths, codes and types for the box-versus-frustum cull test.
`timescale 1ns / 1ps

package afct_pkg;

   localparam int NUM_PLANES_DEFAULT = 6;

   localparam int MODE_W   = 1;
   localparam int IDX_W    = 3;
   localparam int NORMAL_W = 18;
   localparam int COORD_W  = 32;
   localparam int OFFSET_W = 32;
   localparam int FRAC_W   = 16;
   localparam int PROD_W   = NORMAL_W + COORD_W;
   localparam int SCALED_W = OFFSET_W + FRAC_W;
   localparam int SUM_W    = PROD_W + 2;

   localparam logic [MODE_W-1:0] MODE_LOAD = 1'b0;
   localparam logic [MODE_W-1:0] MODE_TEST = 1'b1;

   typedef struct packed {
      logic advance;
      logic load;
   } afct_lane_ctl_type;

endpackage

// ===== rtl/afct_plane_lane.sv =====
// One clipping plane: its stored normal and offset and a three-stage signed distance test.
`timescale 1ns / 1ps

module afct_plane_lane
   import afct_pkg::*;
(
   input  logic                       clock,
   input  afct_lane_ctl_type          ctl,
   input  logic signed [NORMAL_W-1:0] wr_normal_x,
   input  logic signed [NORMAL_W-1:0] wr_normal_y,
   input  logic signed [NORMAL_W-1:0] wr_normal_z,
   input  logic signed [OFFSET_W-1:0] wr_offset,
   input  logic signed [COORD_W-1:0]  min_x,
   input  logic signed [COORD_W-1:0]  min_y,
   input  logic signed [COORD_W-1:0]  min_z,
   input  logic signed [COORD_W-1:0]  max_x,
   input  logic signed [COORD_W-1:0]  max_y,
   input  logic signed [COORD_W-1:0]  max_z,
   output logic                       reject
);

   logic signed [NORMAL_W-1:0] nx_ff, ny_ff, nz_ff;
   logic signed [OFFSET_W-1:0] d_ff;

   logic signed [COORD_W-1:0]  sel_x, sel_y, sel_z;
   logic signed [PROD_W-1:0]   prod_x_in, prod_y_in, prod_z_in;
   logic signed [PROD_W-1:0]   prod_x_ff, prod_y_ff, prod_z_ff;
   logic signed [SCALED_W-1:0] off_in, off_ff;
   logic signed [SUM_W-1:0]    acc_a_in, acc_b_in, acc_a_ff, acc_b_ff;
   logic signed [SUM_W-1:0]    total;
   logic                       reject_in, reject_ff;

   always_ff @(posedge clock) begin
      if (ctl.advance && ctl.load) begin
         nx_ff <= wr_normal_x;
         ny_ff <= wr_normal_y;
         nz_ff <= wr_normal_z;
         d_ff  <= wr_offset;
      end
   end

   // positive vertex: max corner where the normal points up the axis
   always_comb begin
      sel_x     = (nx_ff > 0) ? max_x : min_x;
      sel_y     = (ny_ff > 0) ? max_y : min_y;
      sel_z     = (nz_ff > 0) ? max_z : min_z;
      prod_x_in = PROD_W'(nx_ff) * PROD_W'(sel_x);
      prod_y_in = PROD_W'(ny_ff) * PROD_W'(sel_y);
      prod_z_in = PROD_W'(nz_ff) * PROD_W'(sel_z);
      off_in    = {d_ff, {FRAC_W{1'b0}}};
      acc_a_in  = SUM_W'(prod_x_ff) + SUM_W'(prod_y_ff);
      acc_b_in  = SUM_W'(prod_z_ff) + SUM_W'(off_ff);
      total     = acc_a_ff + acc_b_ff;
      reject_in = total[SUM_W-1];
   end

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         prod_x_ff <= prod_x_in;
         prod_y_ff <= prod_y_in;
         prod_z_ff <= prod_z_in;
         off_ff    <= off_in;
         acc_a_ff  <= acc_a_in;
         acc_b_ff  <= acc_b_in;
         reject_ff <= reject_in;
      end
   end

   assign reject = reject_ff;

endmodule

// ===== rtl/aabb_frustum_cull_test.sv =====
// Top level of the box-versus-frustum cull test: input stage, plane lanes and result register.
`timescale 1ns / 1ps

// Holds NUM_PLANES clipping planes and tests axis-aligned boxes against them with the
// positive vertex rule; a box is visible when no plane gives a negative signed distance.
// A load item (mode 0) writes one plane and gives no result; an index at or above
// NUM_PLANES is dropped. A test item (mode 1) gives one result, and one item can be taken
// every cycle while the result side does not stall. The pipeline is: input register, one
// 18x32 multiplier per plane and axis, two adder stages and the result register;
// 3*NUM_PLANES multipliers work in parallel. A plane is written as its load item
// leaves the input register, so a test taken after a load sees that plane. A stall on the
// result side freezes the whole pipeline. Every plane must be loaded before it is tested.

module aabb_frustum_cull_test
   import afct_pkg::*;
#(
   parameter int NUM_PLANES = NUM_PLANES_DEFAULT
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [MODE_W-1:0]          req_mode,
   input  logic [IDX_W-1:0]           req_plane_index,
   input  logic signed [NORMAL_W-1:0] req_normal_x,
   input  logic signed [NORMAL_W-1:0] req_normal_y,
   input  logic signed [NORMAL_W-1:0] req_normal_z,
   input  logic signed [OFFSET_W-1:0] req_plane_offset,
   input  logic signed [COORD_W-1:0]  req_min_x,
   input  logic signed [COORD_W-1:0]  req_min_y,
   input  logic signed [COORD_W-1:0]  req_min_z,
   input  logic signed [COORD_W-1:0]  req_max_x,
   input  logic signed [COORD_W-1:0]  req_max_y,
   input  logic signed [COORD_W-1:0]  req_max_z,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_visible
);

   logic                       advance;

   logic                       s1_valid_ff;
   logic [MODE_W-1:0]          s1_mode_ff;
   logic [IDX_W-1:0]           s1_idx_ff;
   logic signed [NORMAL_W-1:0] s1_nx_ff, s1_ny_ff, s1_nz_ff;
   logic signed [OFFSET_W-1:0] s1_off_ff;
   logic signed [COORD_W-1:0]  s1_lx_ff, s1_ly_ff, s1_lz_ff;
   logic signed [COORD_W-1:0]  s1_hx_ff, s1_hy_ff, s1_hz_ff;

   logic                       s2_valid_in;
   logic                       s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic                       rsp_valid_ff;
   logic                       rsp_visible_in, rsp_visible_ff;

   logic [NUM_PLANES-1:0]      lane_reject;
   afct_lane_ctl_type          lane_ctl [NUM_PLANES];

   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_mode_ff <= req_mode;
         s1_idx_ff  <= req_plane_index;
         s1_nx_ff   <= req_normal_x;
         s1_ny_ff   <= req_normal_y;
         s1_nz_ff   <= req_normal_z;
         s1_off_ff  <= req_plane_offset;
         s1_lx_ff   <= req_min_x;
         s1_ly_ff   <= req_min_y;
         s1_lz_ff   <= req_min_z;
         s1_hx_ff   <= req_max_x;
         s1_hy_ff   <= req_max_y;
         s1_hz_ff   <= req_max_z;
      end
   end

   genvar g;
   generate
      for (g = 0; g < NUM_PLANES; g++) begin : g_lane
         always_comb begin
            lane_ctl[g].advance = advance;
            lane_ctl[g].load    = s1_valid_ff && (s1_mode_ff == MODE_LOAD)
                                  && (s1_idx_ff == IDX_W'(g));
         end

         afct_plane_lane u_lane (
            .clock       (clock),
            .ctl         (lane_ctl[g]),
            .wr_normal_x (s1_nx_ff),
            .wr_normal_y (s1_ny_ff),
            .wr_normal_z (s1_nz_ff),
            .wr_offset   (s1_off_ff),
            .min_x       (s1_lx_ff),
            .min_y       (s1_ly_ff),
            .min_z       (s1_lz_ff),
            .max_x       (s1_hx_ff),
            .max_y       (s1_hy_ff),
            .max_z       (s1_hz_ff),
            .reject      (lane_reject[g])
         );
      end
   endgenerate

   // only test items travel past the input register
   assign s2_valid_in    = s1_valid_ff && (s1_mode_ff == MODE_TEST);
   assign rsp_visible_in = ~|lane_reject;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= req_valid;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         rsp_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_visible_ff <= rsp_visible_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_visible = rsp_visible_ff;

   a_load_no_result: assert property (@(posedge clock) disable iff (reset)
      advance && s1_valid_ff && (s1_mode_ff == MODE_LOAD) |=> !s2_valid_ff)
      else $error("load item entered the test stages");

   a_freeze_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(s2_valid_ff) && $stable(s3_valid_ff) && $stable(s4_valid_ff)
                   && $stable(s1_valid_ff))
      else $error("pipeline moved while frozen");

   a_result_follows_test: assert property (@(posedge clock) disable iff (reset)
      advance && s4_valid_ff |=> rsp_valid_ff)
      else $error("test item lost before the result register");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !s1_valid_ff)
      else $error("valid bits not cleared by reset");

endmodule
